### rtl/ir_pulse_frame_decoder_defines.svh
// assertion macros for the ir pulse frame decoder checker
`ifndef IR_PULSE_FRAME_DECODER_DEFINES_SVH
`define IR_PULSE_FRAME_DECODER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define IRPFD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("irpfd assertion failed");

// next-cycle implication, checked out of reset
`define IRPFD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("irpfd assertion failed");

`endif

### rtl/irpfd_pkg.sv
package irpfd_pkg;

   // one edge event beat
   typedef struct packed {
      logic       pin_level;
      logic [6:0] duration;
   } item_type;

   // result kinds
   localparam logic [1:0] KIND_FRAME  = 2'd0;
   localparam logic [1:0] KIND_REPEAT = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   // error codes
   localparam logic [2:0] ERR_NONE  = 3'd0;
   localparam logic [2:0] ERR_GAP   = 3'd1;
   localparam logic [2:0] ERR_PULSE = 3'd2;
   localparam logic [2:0] ERR_BIT   = 3'd3;
   localparam logic [2:0] ERR_SEP   = 3'd4;

   // timing windows in ticks
   localparam logic [6:0] LEADER_MIN     = 7'd30;
   localparam logic [6:0] LEADER_MAX_ALT = 7'd40;
   localparam logic [6:0] LEADER_MAX_NEC = 7'd75;
   localparam logic [6:0] GAP_MIN        = 7'd30;
   localparam logic [6:0] GAP_MAX        = 7'd40;
   localparam logic [6:0] REPEAT_MIN     = 7'd15;
   localparam logic [6:0] REPEAT_MAX     = 7'd20;
   localparam logic [6:0] SHORT_MIN      = 7'd2;
   localparam logic [6:0] SHORT_MAX      = 7'd7;
   localparam logic [6:0] LONG_MIN       = 7'd9;
   localparam logic [6:0] LONG_MAX       = 7'd19;

   // field sizes in bits
   localparam logic [3:0] BYTE_BITS    = 4'd8;
   localparam logic [3:0] PRODUCT_BITS = 4'd4;

endpackage

### rtl/irpfd_in_stage.sv
module irpfd_in_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  irpfd_pkg::item_type req_item,
   output logic                item_valid,
   output irpfd_pkg::item_type item,
   input  logic                item_take
);

   logic                item_valid_ff;
   logic                item_valid_in;
   irpfd_pkg::item_type item_ff;
   logic                accept;

   // hold a beat until the decoder takes it
   assign req_stall = item_valid_ff && !item_take;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         item_valid_in = 1'b1;
      end else if (item_take) begin
         item_valid_in = 1'b0;
      end else begin
         item_valid_in = item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
      if (accept) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = item_valid_ff;
   assign item       = item_ff;

endmodule

### rtl/irpfd_frame_fsm.sv
module irpfd_frame_fsm (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic                csr_wr_data,
   input  logic                item_valid,
   input  irpfd_pkg::item_type item,
   output logic                item_take,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_kind,
   output logic [2:0]          rsp_error_code,
   output logic [7:0]          rsp_address_low,
   output logic [7:0]          rsp_address_high,
   output logic [3:0]          rsp_product,
   output logic [7:0]          rsp_command_low,
   output logic [7:0]          rsp_command_high
);

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_GAP      = 4'd1,
      PH_ADRL_PRE = 4'd2,
      PH_ADRL_BIT = 4'd3,
      PH_ADRH_PRE = 4'd4,
      PH_ADRH_BIT = 4'd5,
      PH_SEP_PRE  = 4'd6,
      PH_SEP      = 4'd7,
      PH_PROD_PRE = 4'd8,
      PH_PROD_BIT = 4'd9,
      PH_CMDL_PRE = 4'd10,
      PH_CMDL_BIT = 4'd11,
      PH_CMDH_PRE = 4'd12,
      PH_CMDH_BIT = 4'd13
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [3:0] bit_count_ff, bit_count_in;
   logic [7:0] addr_lo_ff, addr_lo_in;
   logic [7:0] addr_hi_ff, addr_hi_in;
   logic [3:0] product_ff, product_in;
   logic [7:0] cmd_lo_ff, cmd_lo_in;
   logic [7:0] cmd_hi_ff, cmd_hi_in;
   logic       mode_ff;

   logic       rsp_valid_ff;
   logic [1:0] kind_ff;
   logic [2:0] error_code_ff;
   logic [7:0] rsp_addr_lo_ff, rsp_addr_hi_ff, rsp_cmd_lo_ff, rsp_cmd_hi_ff;
   logic [3:0] rsp_product_ff;

   logic       emit;
   logic [1:0] kind;
   logic [2:0] error_code;

   logic [6:0] d;
   logic       alt;
   logic       leader_hit, w_gap, w_repeat, w_short, w_long, bit_ok;
   logic [6:0] leader_max;
   logic [3:0] bit_count_inc;
   logic [2:0] bit_idx;

   // window compares on the held duration
   assign d          = item.duration;
   assign alt        = mode_ff;
   assign leader_max = alt ? irpfd_pkg::LEADER_MAX_ALT : irpfd_pkg::LEADER_MAX_NEC;
   assign leader_hit = item.pin_level && d >= irpfd_pkg::LEADER_MIN && d <= leader_max;
   assign w_gap      = d >= irpfd_pkg::GAP_MIN && d <= irpfd_pkg::GAP_MAX;
   assign w_repeat   = d >= irpfd_pkg::REPEAT_MIN && d <= irpfd_pkg::REPEAT_MAX;
   assign w_short    = d >= irpfd_pkg::SHORT_MIN && d <= irpfd_pkg::SHORT_MAX;
   assign w_long     = d >= irpfd_pkg::LONG_MIN && d <= irpfd_pkg::LONG_MAX;
   assign bit_ok     = w_short || w_long;

   assign bit_count_inc = bit_count_ff + 4'd1;
   assign bit_idx       = bit_count_ff[2:0];

   // an event moves on once the result register is free or draining
   assign item_take = item_valid && (!rsp_valid_ff || !rsp_stall);

   // next frame state and result for the held event
   always_comb begin
      phase_in     = phase_ff;
      bit_count_in = bit_count_ff;
      addr_lo_in   = addr_lo_ff;
      addr_hi_in   = addr_hi_ff;
      product_in   = product_ff;
      cmd_lo_in    = cmd_lo_ff;
      cmd_hi_in    = cmd_hi_ff;
      emit         = 1'b0;
      kind         = irpfd_pkg::KIND_ERROR;
      error_code   = irpfd_pkg::ERR_NONE;

      if (leader_hit) begin
         phase_in = PH_GAP;
      end else begin
         case (phase_ff)
            PH_GAP: begin
               if (w_gap) begin
                  phase_in     = PH_ADRL_PRE;
                  bit_count_in = 4'd0;
               end else if (w_repeat) begin
                  phase_in = PH_IDLE;
                  emit     = 1'b1;
                  kind     = irpfd_pkg::KIND_REPEAT;
               end else begin
                  phase_in   = PH_IDLE;
                  emit       = 1'b1;
                  error_code = irpfd_pkg::ERR_GAP;
               end
            end
            PH_SEP_PRE, PH_PROD_PRE, PH_ADRL_PRE, PH_ADRH_PRE, PH_CMDL_PRE,
            PH_CMDH_PRE: begin
               // separator and product pulses only count in alternate mode
               if (alt || !(phase_ff == PH_SEP_PRE || phase_ff == PH_PROD_PRE)) begin
                  if (w_short) begin
                     phase_in = phase_type'(phase_ff + 4'd1);
                  end else begin
                     phase_in   = PH_IDLE;
                     emit       = 1'b1;
                     error_code = irpfd_pkg::ERR_PULSE;
                  end
               end
            end
            PH_SEP: begin
               if (alt) begin
                  if (w_gap) begin
                     phase_in     = PH_PROD_PRE;
                     bit_count_in = 4'd0;
                  end else begin
                     phase_in   = PH_IDLE;
                     emit       = 1'b1;
                     error_code = irpfd_pkg::ERR_SEP;
                  end
               end
            end
            PH_ADRL_BIT, PH_ADRH_BIT, PH_PROD_BIT, PH_CMDL_BIT, PH_CMDH_BIT: begin
               if (phase_ff == PH_PROD_BIT && !alt) begin
                  phase_in = phase_ff;
               end else if (!bit_ok) begin
                  phase_in   = PH_IDLE;
                  emit       = 1'b1;
                  error_code = irpfd_pkg::ERR_BIT;
               end else begin
                  // shift in one data bit, lsb first
                  bit_count_in = bit_count_inc;
                  phase_in     = phase_type'(phase_ff - 4'd1);
                  case (phase_ff)
                     PH_ADRL_BIT: begin
                        addr_lo_in[bit_idx] = w_long;
                        if (bit_count_inc >= irpfd_pkg::BYTE_BITS) begin
                           phase_in     = PH_ADRH_PRE;
                           bit_count_in = 4'd0;
                        end
                     end
                     PH_ADRH_BIT: begin
                        addr_hi_in[bit_idx] = w_long;
                        if (bit_count_inc >= irpfd_pkg::BYTE_BITS) begin
                           phase_in     = alt ? PH_SEP_PRE : PH_CMDL_PRE;
                           bit_count_in = 4'd0;
                        end
                     end
                     PH_PROD_BIT: begin
                        if (!bit_idx[2]) begin
                           product_in[bit_idx[1:0]] = w_long;
                        end
                        if (bit_count_inc >= irpfd_pkg::PRODUCT_BITS) begin
                           phase_in     = PH_CMDL_PRE;
                           bit_count_in = 4'd0;
                        end
                     end
                     PH_CMDL_BIT: begin
                        cmd_lo_in[bit_idx] = w_long;
                        if (bit_count_inc >= irpfd_pkg::BYTE_BITS) begin
                           phase_in     = PH_CMDH_PRE;
                           bit_count_in = 4'd0;
                        end
                     end
                     default: begin
                        cmd_hi_in[bit_idx] = w_long;
                        if (bit_count_inc >= irpfd_pkg::BYTE_BITS) begin
                           phase_in     = PH_IDLE;
                           bit_count_in = 4'd0;
                           emit         = 1'b1;
                           kind         = irpfd_pkg::KIND_FRAME;
                        end
                     end
                  endcase
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   // frame state, mode register and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bit_count_ff <= 4'd0;
         addr_lo_ff   <= 8'd0;
         addr_hi_ff   <= 8'd0;
         product_ff   <= 4'd0;
         cmd_lo_ff    <= 8'd0;
         cmd_hi_ff    <= 8'd0;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         if (item_take) begin
            phase_ff     <= phase_in;
            bit_count_ff <= bit_count_in;
            addr_lo_ff   <= addr_lo_in;
            addr_hi_ff   <= addr_hi_in;
            product_ff   <= product_in;
            cmd_lo_ff    <= cmd_lo_in;
            cmd_hi_ff    <= cmd_hi_in;
         end
         if (item_take && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (item_take && emit) begin
         kind_ff        <= kind;
         error_code_ff  <= error_code;
         rsp_addr_lo_ff <= addr_lo_in;
         rsp_addr_hi_ff <= addr_hi_in;
         rsp_product_ff <= product_in;
         rsp_cmd_lo_ff  <= cmd_lo_in;
         rsp_cmd_hi_ff  <= cmd_hi_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_error_code   = error_code_ff;
   assign rsp_address_low  = rsp_addr_lo_ff;
   assign rsp_address_high = rsp_addr_hi_ff;
   assign rsp_product      = rsp_product_ff;
   assign rsp_command_low  = rsp_cmd_lo_ff;
   assign rsp_command_high = rsp_cmd_hi_ff;

endmodule

### rtl/ir_pulse_frame_decoder.sv
// Infrared remote frame decoder, NEC framing or an alternate framing with a
// separator and a product nibble (csr_wr_data selects: 0 NEC, 1 alternate).
// Request channel: one beat per receiver edge, req_pin_level is the level
// after the edge and req_duration the length in ticks of the interval that
// just ended. A beat is taken when req_valid is high and req_stall is low.
// Response channel: at most one beat per request beat, for a complete frame,
// a key repeat or a decode error, with the held address, product and command.
// A taken request beat passes the input register, then the result register;
// one request beat per cycle while req_stall is low, each decoded in a single
// pass through the frame state machine. When rsp_stall is high the result
// register holds; one more request beat is still taken into the input register,
// then req_stall rises until the result drains. The user must write the mode
// register with csr_wr_en only while the block is idle; the block does not
// enforce it. Synchronous reset: idle, held data cleared, NEC mode selected.
module ir_pulse_frame_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_pin_level,
   input  logic [6:0] req_duration,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [2:0] rsp_error_code,
   output logic [7:0] rsp_address_low,
   output logic [7:0] rsp_address_high,
   output logic [3:0] rsp_product,
   output logic [7:0] rsp_command_low,
   output logic [7:0] rsp_command_high,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   irpfd_pkg::item_type req_item;
   irpfd_pkg::item_type item;
   logic                item_valid;
   logic                item_take;

   assign req_item.pin_level = req_pin_level;
   assign req_item.duration  = req_duration;

   // input register
   irpfd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   // frame state machine and result register
   irpfd_frame_fsm u_frame_fsm (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .item_valid       (item_valid),
      .item             (item),
      .item_take        (item_take),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_error_code   (rsp_error_code),
      .rsp_address_low  (rsp_address_low),
      .rsp_address_high (rsp_address_high),
      .rsp_product      (rsp_product),
      .rsp_command_low  (rsp_command_low),
      .rsp_command_high (rsp_command_high)
   );

endmodule

### rtl/irpfd_checker.sv
`include "ir_pulse_frame_decoder_defines.svh"

module irpfd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_kind,
   input logic [2:0] rsp_error_code
);

   // a stalled response beat stays
   `IRPFD_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)

   // no response beat without a request beat taken before it
   `IRPFD_ASSERT_NEXT(a_rsp_cause, (!req_valid && !req_stall) ##1 !rsp_valid, !rsp_valid)

   // only the three result kinds appear
   `IRPFD_ASSERT_NOW(a_kind_legal, rsp_valid,
      rsp_kind == irpfd_pkg::KIND_FRAME || rsp_kind == irpfd_pkg::KIND_REPEAT ||
      rsp_kind == irpfd_pkg::KIND_ERROR)

   // frames and repeats carry no error code
   `IRPFD_ASSERT_NOW(a_code_clear, rsp_valid && rsp_kind != irpfd_pkg::KIND_ERROR,
      rsp_error_code == irpfd_pkg::ERR_NONE)

   // an error always carries one of the defined codes
   `IRPFD_ASSERT_NOW(a_code_set, rsp_valid && rsp_kind == irpfd_pkg::KIND_ERROR,
      rsp_error_code == irpfd_pkg::ERR_GAP || rsp_error_code == irpfd_pkg::ERR_PULSE ||
      rsp_error_code == irpfd_pkg::ERR_BIT || rsp_error_code == irpfd_pkg::ERR_SEP)

endmodule

bind ir_pulse_frame_decoder irpfd_checker u_irpfd_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_kind       (rsp_kind),
   .rsp_error_code (rsp_error_code)
);

### tb/ir_pulse_frame_decoder_tb.sv
module ir_pulse_frame_decoder_tb;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 300;
   localparam int SETTLE_CYCLES  = 8;
   localparam int RANDOM_PHASES  = 6;

   // frame states of the decoder model
   typedef enum logic [3:0] {
      ST_IDLE     = 4'd0,
      ST_GAP      = 4'd1,
      ST_ADRL_PRE = 4'd2,
      ST_ADRL_BIT = 4'd3,
      ST_ADRH_PRE = 4'd4,
      ST_ADRH_BIT = 4'd5,
      ST_SEP_PRE  = 4'd6,
      ST_SEP      = 4'd7,
      ST_PROD_PRE = 4'd8,
      ST_PROD_BIT = 4'd9,
      ST_CMDL_PRE = 4'd10,
      ST_CMDL_BIT = 4'd11,
      ST_CMDH_PRE = 4'd12,
      ST_CMDH_BIT = 4'd13
   } frame_state_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] code;
      logic [7:0] addr_lo;
      logic [7:0] addr_hi;
      logic [3:0] product;
      logic [7:0] cmd_lo;
      logic [7:0] cmd_hi;
   } decode_report_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_pin_level = 1'b0;
   logic [6:0] req_duration = 7'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_kind;
   logic [2:0] rsp_error_code;
   logic [7:0] rsp_address_low;
   logic [7:0] rsp_address_high;
   logic [3:0] rsp_product;
   logic [7:0] rsp_command_low;
   logic [7:0] rsp_command_high;
   logic       csr_wr_en = 1'b0;
   logic       csr_wr_data = 1'b0;

   ir_pulse_frame_decoder uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pin_level    (req_pin_level),
      .req_duration     (req_duration),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_error_code   (rsp_error_code),
      .rsp_address_low  (rsp_address_low),
      .rsp_address_high (rsp_address_high),
      .rsp_product      (rsp_product),
      .rsp_command_low  (rsp_command_low),
      .rsp_command_high (rsp_command_high),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always #6 clock = ~clock;

   // decoder model state
   logic            alt_mode = 1'b0;
   frame_state_type frame_st = ST_IDLE;
   logic [3:0]      bit_cnt = 4'd0;
   logic [7:0]      held_addr_lo = 8'd0;
   logic [7:0]      held_addr_hi = 8'd0;
   logic [3:0]      held_product = 4'd0;
   logic [7:0]      held_cmd_lo = 8'd0;
   logic [7:0]      held_cmd_hi = 8'd0;

   decode_report_type   expected_reports[$];
   irpfd_pkg::item_type pending_items[$];
   irpfd_pkg::item_type frame_buf[$];

   int error_count = 0;
   int reports_seen = 0;
   int stim_items = 0;
   int send_gap = 0;
   int stall_left = 0;
   int idle_cycles = 0;
   bit long_hold_done = 1'b0;
   bit quiet = 1'b0;

   int border_ticks[9] = '{0, 1, 8, 14, 21, 29, 41, 76, 127};

   function automatic bit in_window(input logic [6:0] d, input logic [6:0] lo,
                                    input logic [6:0] hi);
      return d >= lo && d <= hi;
   endfunction

   function automatic void push_report(input logic [1:0] kind, input logic [2:0] code);
      decode_report_type r;
      r.kind    = kind;
      r.code    = code;
      r.addr_lo = held_addr_lo;
      r.addr_hi = held_addr_hi;
      r.product = held_product;
      r.cmd_lo  = held_cmd_lo;
      r.cmd_hi  = held_cmd_hi;
      expected_reports.push_back(r);
   endfunction

   function automatic void decode_fail(input logic [2:0] code);
      frame_st = ST_IDLE;
      push_report(irpfd_pkg::KIND_ERROR, code);
   endfunction

   // shift one bit into a field; 1 when the field is complete, -1 on a bad gap
   function automatic int take_bit(input logic [6:0] d, input logic [3:0] size,
                                   input frame_state_type next_st,
                                   inout logic [7:0] field);
      if (in_window(d, irpfd_pkg::SHORT_MIN, irpfd_pkg::SHORT_MAX))
         field[bit_cnt[2:0]] = 1'b0;
      else if (in_window(d, irpfd_pkg::LONG_MIN, irpfd_pkg::LONG_MAX))
         field[bit_cnt[2:0]] = 1'b1;
      else
         return -1;
      bit_cnt = bit_cnt + 4'd1;
      if (bit_cnt >= size) begin
         frame_st = next_st;
         bit_cnt = 4'd0;
         return 1;
      end
      frame_st = frame_state_type'(frame_st - 4'd1);
      return 0;
   endfunction

   // one accepted edge beat through the frame state machine
   function automatic void decode_beat(input logic level, input logic [6:0] d);
      int         r;
      logic [7:0] nib;
      r = 0;
      if (level && in_window(d, irpfd_pkg::LEADER_MIN,
                             alt_mode ? irpfd_pkg::LEADER_MAX_ALT : irpfd_pkg::LEADER_MAX_NEC))
      begin
         frame_st = ST_GAP;
         return;
      end
      case (frame_st)
         ST_GAP: begin
            if (in_window(d, irpfd_pkg::GAP_MIN, irpfd_pkg::GAP_MAX)) begin
               frame_st = ST_ADRL_PRE;
               bit_cnt = 4'd0;
            end else if (in_window(d, irpfd_pkg::REPEAT_MIN, irpfd_pkg::REPEAT_MAX)) begin
               frame_st = ST_IDLE;
               push_report(irpfd_pkg::KIND_REPEAT, irpfd_pkg::ERR_NONE);
            end else begin
               decode_fail(irpfd_pkg::ERR_GAP);
            end
            return;
         end
         ST_SEP_PRE, ST_PROD_PRE, ST_ADRL_PRE, ST_ADRH_PRE, ST_CMDL_PRE, ST_CMDH_PRE: begin
            // separator and product phases sleep in nec mode
            if (!alt_mode && (frame_st == ST_SEP_PRE || frame_st == ST_PROD_PRE))
               return;
            if (in_window(d, irpfd_pkg::SHORT_MIN, irpfd_pkg::SHORT_MAX))
               frame_st = frame_state_type'(frame_st + 4'd1);
            else
               decode_fail(irpfd_pkg::ERR_PULSE);
            return;
         end
         ST_ADRL_BIT: r = take_bit(d, irpfd_pkg::BYTE_BITS, ST_ADRH_PRE, held_addr_lo);
         ST_ADRH_BIT:
            r = take_bit(d, irpfd_pkg::BYTE_BITS, alt_mode ? ST_SEP_PRE : ST_CMDL_PRE,
                         held_addr_hi);
         ST_SEP: begin
            if (!alt_mode)
               return;
            if (in_window(d, irpfd_pkg::GAP_MIN, irpfd_pkg::GAP_MAX)) begin
               frame_st = ST_PROD_PRE;
               bit_cnt = 4'd0;
            end else begin
               decode_fail(irpfd_pkg::ERR_SEP);
            end
            return;
         end
         ST_PROD_BIT: begin
            if (!alt_mode)
               return;
            nib = {4'd0, held_product};
            r = take_bit(d, irpfd_pkg::PRODUCT_BITS, ST_CMDL_PRE, nib);
            held_product = nib[3:0];
         end
         ST_CMDL_BIT: r = take_bit(d, irpfd_pkg::BYTE_BITS, ST_CMDH_PRE, held_cmd_lo);
         ST_CMDH_BIT: begin
            r = take_bit(d, irpfd_pkg::BYTE_BITS, ST_IDLE, held_cmd_hi);
            if (r == 1)
               push_report(irpfd_pkg::KIND_FRAME, irpfd_pkg::ERR_NONE);
         end
         default: begin
            frame_st = ST_IDLE;
            return;
         end
      endcase
      if (r < 0)
         decode_fail(irpfd_pkg::ERR_BIT);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at report %0d, %s: got %0d expected %0d", reports_seen, what, got,
               want);
      error_count++;
   endtask

   task automatic check_report();
      decode_report_type want;
      if (expected_reports.size() == 0) begin
         report_mismatch("unexpected report, kind", rsp_kind, 0);
         return;
      end
      want = expected_reports.pop_front();
      if (rsp_kind !== want.kind)
         report_mismatch("kind", rsp_kind, want.kind);
      if (rsp_error_code !== want.code)
         report_mismatch("error_code", rsp_error_code, want.code);
      if (rsp_address_low !== want.addr_lo)
         report_mismatch("address_low", rsp_address_low, want.addr_lo);
      if (rsp_address_high !== want.addr_hi)
         report_mismatch("address_high", rsp_address_high, want.addr_hi);
      if (rsp_product !== want.product)
         report_mismatch("product", rsp_product, want.product);
      if (rsp_command_low !== want.cmd_lo)
         report_mismatch("command_low", rsp_command_low, want.cmd_lo);
      if (rsp_command_high !== want.cmd_hi)
         report_mismatch("command_high", rsp_command_high, want.cmd_hi);
   endtask

   // request driver, predicts each beat as it is taken
   always @(posedge clock) begin : drive_beats
      irpfd_pkg::item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            decode_beat(req_pin_level, req_duration);
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               nxt = pending_items.pop_front();
               req_valid <= 1'b1;
               req_pin_level <= nxt.pin_level;
               req_duration <= nxt.duration;
               if (!quiet && $urandom_range(0, 15) == 0)
                  send_gap = $urandom_range(1, 10);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor with random and long hold-offs
   always @(posedge clock) begin : watch_reports
      logic hold_next;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_report();
            reports_seen++;
            if (!long_hold_done && !quiet && reports_seen >= 8 && pending_items.size() > 40)
            begin
               long_hold_done = 1'b1;
               stall_left = LONG_HOLD;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            hold_next = 1'b1;
         end else if (!quiet && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(0, 9);
            hold_next = 1'b1;
         end else begin
            hold_next = 1'b0;
         end
         rsp_stall <= hold_next;
      end
   end

   // no beat on either side for too long ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   function automatic irpfd_pkg::item_type make_item(input logic level, input int ticks);
      irpfd_pkg::item_type it;
      it.pin_level = level;
      it.duration = ticks[6:0];
      return it;
   endfunction

   function automatic void add_item(input logic level, input int ticks, input bit counted);
      pending_items.push_back(make_item(level, ticks));
      if (counted)
         stim_items++;
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hff;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic irpfd_pkg::item_type bad_item();
      if ($urandom_range(0, 1))
         return make_item(1'($urandom_range(0, 1)), border_ticks[$urandom_range(0, 8)]);
      return make_item(1'($urandom_range(0, 1)), $urandom_range(0, 127));
   endfunction

   // pulse and gap pairs for one field, lsb first
   function automatic void buf_field(input logic [7:0] value, input int nbits);
      for (int i = 0; i < nbits; i++) begin
         frame_buf.push_back(make_item(1'($urandom_range(0, 1)),
                             $urandom_range(irpfd_pkg::SHORT_MIN, irpfd_pkg::SHORT_MAX)));
         if (value[i])
            frame_buf.push_back(make_item(1'($urandom_range(0, 1)),
                                $urandom_range(irpfd_pkg::LONG_MIN, irpfd_pkg::LONG_MAX)));
         else
            frame_buf.push_back(make_item(1'($urandom_range(0, 1)),
                                $urandom_range(irpfd_pkg::SHORT_MIN, irpfd_pkg::SHORT_MAX)));
      end
   endfunction

   function automatic void build_frame(input logic alt);
      logic [7:0] cmd;
      logic [7:0] cmd_inv;
      frame_buf.delete();
      frame_buf.push_back(make_item(1'b1, $urandom_range(irpfd_pkg::LEADER_MIN,
                          alt ? irpfd_pkg::LEADER_MAX_ALT : irpfd_pkg::LEADER_MAX_NEC)));
      frame_buf.push_back(make_item(1'b0,
                          $urandom_range(irpfd_pkg::GAP_MIN, irpfd_pkg::GAP_MAX)));
      buf_field(pick_byte(), 8);
      buf_field(pick_byte(), 8);
      if (alt) begin
         frame_buf.push_back(make_item(1'($urandom_range(0, 1)),
                             $urandom_range(irpfd_pkg::SHORT_MIN, irpfd_pkg::SHORT_MAX)));
         frame_buf.push_back(make_item(1'b0,
                             $urandom_range(irpfd_pkg::GAP_MIN, irpfd_pkg::GAP_MAX)));
         buf_field(8'($urandom_range(0, 15)), 4);
      end
      cmd = pick_byte();
      cmd_inv = ~cmd;
      buf_field(cmd, 8);
      buf_field($urandom_range(0, 1) ? cmd_inv : pick_byte(), 8);
   endfunction

   function automatic void flush_frame(input int count);
      for (int i = 0; i < count && i < frame_buf.size(); i++) begin
         pending_items.push_back(frame_buf[i]);
         stim_items++;
      end
   endfunction

   // well-formed frames with random content, plus damaged frames, repeats and noise
   task automatic queue_random_phase(input logic alt, input int target_items,
                                     input int target_seqs);
      int start_items;
      int seqs;
      int pick;
      int cut;
      start_items = stim_items;
      seqs = 0;
      // leftovers of an alternate frame are ignored in nec mode
      if (!alt)
         repeat ($urandom_range(1, 3)) add_item(1'b0, $urandom_range(0, 127), 1'b0);
      while (stim_items - start_items < target_items || seqs < target_seqs) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            build_frame(alt);
            flush_frame(frame_buf.size());
            seqs++;
         end else if (pick < 65) begin
            build_frame(alt);
            if (alt && $urandom_range(0, 3) == 0)
               cut = 35;
            else
               cut = $urandom_range(1, frame_buf.size() - 1);
            frame_buf[cut] = bad_item();
            flush_frame(cut + 1);
            seqs++;
         end else if (pick < 90) begin
            add_item(1'b1, $urandom_range(irpfd_pkg::LEADER_MIN,
                     alt ? irpfd_pkg::LEADER_MAX_ALT : irpfd_pkg::LEADER_MAX_NEC), 1'b1);
            if ($urandom_range(0, 4) != 0) begin
               add_item(1'($urandom_range(0, 1)),
                        $urandom_range(irpfd_pkg::REPEAT_MIN, irpfd_pkg::REPEAT_MAX), 1'b1);
            end else begin
               pending_items.push_back(bad_item());
               stim_items++;
            end
            seqs++;
         end else begin
            repeat ($urandom_range(1, 3))
               add_item(1'($urandom_range(0, 1)), $urandom_range(0, 127), 1'b0);
         end
      end
      // stop inside the separator or product field before a mode change
      if (alt) begin
         build_frame(1'b1);
         flush_frame($urandom_range(34, 43));
      end
   endtask

   task automatic write_mode(input logic m);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      alt_mode = m;
   endtask

   task automatic wait_drained();
      do
         @(negedge clock);
      while (pending_items.size() != 0 || req_valid || expected_reports.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin : run_test
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // nec windows, repeats and the gap, pulse and bit error paths
      write_mode(1'b0);
      add_item(1'b0, 127, 1'b1);
      add_item(1'b1, 0, 1'b1);
      add_item(1'b1, 29, 1'b1);
      add_item(1'b1, 76, 1'b1);
      add_item(1'b1, 75, 1'b1);
      add_item(1'b0, 20, 1'b1);
      add_item(1'b1, 30, 1'b1);
      add_item(1'b1, 15, 1'b1);
      add_item(1'b1, 50, 1'b1);
      add_item(1'b0, 41, 1'b1);
      add_item(1'b1, 30, 1'b1);
      add_item(1'b0, 30, 1'b1);
      add_item(1'b0, 8, 1'b1);
      add_item(1'b1, 75, 1'b1);
      add_item(1'b0, 40, 1'b1);
      add_item(1'b1, 2, 1'b1);
      add_item(1'b0, 8, 1'b1);
      // leader in the middle of the address restarts the frame
      add_item(1'b1, 60, 1'b1);
      add_item(1'b0, 35, 1'b1);
      add_item(1'b1, 7, 1'b1);
      add_item(1'b0, 19, 1'b1);
      add_item(1'b1, 3, 1'b1);
      add_item(1'b1, 60, 1'b1);
      add_item(1'b0, 16, 1'b1);
      wait_drained();

      // alternate mode has a narrower leader window
      write_mode(1'b1);
      add_item(1'b1, 41, 1'b1);
      add_item(1'b1, 40, 1'b1);
      add_item(1'b0, 17, 1'b1);
      wait_drained();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == RANDOM_PHASES - 1)
            quiet = 1'b1;
         write_mode((p % 2) == 0);
         queue_random_phase((p % 2) == 0, 70, 2);
         wait_drained();
      end

      if (expected_reports.size() != 0)
         report_mismatch("reports never delivered", 0, expected_reports.size());
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
